// ----- src/htsc_pkg.sv -----
// Types, constants and jamo lookup functions of the two-set Hangul composer.
// Used by every module of the block; depends on nothing else.
package htsc_pkg;

  localparam logic [4:0]  NONE_IDX   = 5'd31;
  localparam logic [4:0]  MAX_INI    = 5'd18;
  localparam logic [4:0]  MAX_MED    = 5'd20;
  localparam logic [4:0]  MAX_FIN    = 5'd27;
  localparam logic [15:0] SYL_BASE   = 16'hAC00;
  localparam logic [15:0] INI_STRIDE = 16'd588;
  localparam logic [15:0] MED_STRIDE = 16'd28;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [5:0]  UTF8_MASK6 = 6'h3F;

  localparam logic CMD_KEY    = 1'b0;
  localparam logic CMD_COMMIT = 1'b1;
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_INI  = 5'b00010,
    PH_MED  = 5'b00100,
    PH_FIN  = 5'b01000,
    PH_CMP  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_value;
    logic       last;
  } out_item_t;

  // One key's worth of edit work: deletes, up to two syllables, or a passthrough byte.
  typedef struct packed {
    logic       del;
    logic       a_ins;
    logic [4:0] a_ini;
    logic [4:0] a_med;
    logic [4:0] a_fin;
    logic       b_ins;
    logic [4:0] b_ini;
    logic [4:0] b_med;
    logic [4:0] b_fin;
    logic       pass;
    logic [7:0] pass_byte;
  } job_t;

  function automatic logic [4:0] key_initial(input logic [7:0] k);
    logic [4:0] r;
    case (k)
      "r": r = 5'd0;   "R": r = 5'd1;   "s": r = 5'd2;
      "e": r = 5'd3;   "E": r = 5'd4;   "f": r = 5'd5;
      "a": r = 5'd6;   "q": r = 5'd7;   "Q": r = 5'd8;
      "t": r = 5'd9;   "T": r = 5'd10;  "d": r = 5'd11;
      "w": r = 5'd12;  "W": r = 5'd13;  "c": r = 5'd14;
      "z": r = 5'd15;  "x": r = 5'd16;  "v": r = 5'd17;
      "g": r = 5'd18;
      default: r = NONE_IDX;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] key_medial(input logic [7:0] k);
    logic [4:0] r;
    case (k)
      "k": r = 5'd0;   "o": r = 5'd1;   "i": r = 5'd2;
      "O": r = 5'd3;   "j": r = 5'd4;   "p": r = 5'd5;
      "u": r = 5'd6;   "P": r = 5'd7;   "h": r = 5'd8;
      "y": r = 5'd12;  "n": r = 5'd13;  "b": r = 5'd17;
      "m": r = 5'd18;  "l": r = 5'd20;
      default: r = NONE_IDX;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] key_final(input logic [7:0] k);
    logic [4:0] r;
    case (k)
      "r": r = 5'd1;   "R": r = 5'd2;   "s": r = 5'd4;
      "e": r = 5'd7;   "f": r = 5'd8;   "a": r = 5'd16;
      "q": r = 5'd17;  "t": r = 5'd19;  "T": r = 5'd20;
      "d": r = 5'd21;  "w": r = 5'd22;  "c": r = 5'd23;
      "z": r = 5'd24;  "x": r = 5'd25;  "v": r = 5'd26;
      "g": r = 5'd27;
      default: r = NONE_IDX;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] fin_to_ini(input logic [4:0] f);
    logic [4:0] r;
    case (f)
      5'd1:  r = 5'd0;   5'd2:  r = 5'd1;   5'd4:  r = 5'd2;
      5'd7:  r = 5'd3;   5'd8:  r = 5'd5;   5'd16: r = 5'd6;
      5'd17: r = 5'd7;   5'd19: r = 5'd9;   5'd20: r = 5'd10;
      5'd21: r = 5'd11;  5'd22: r = 5'd12;  5'd23: r = 5'd14;
      5'd24: r = 5'd15;  5'd25: r = 5'd16;  5'd26: r = 5'd17;
      5'd27: r = 5'd18;
      default: r = NONE_IDX;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] merge_vowel(input logic [4:0] a, input logic [4:0] b);
    logic [4:0] r;
    r = NONE_IDX;
    if (a == 5'd8) begin
      if (b == 5'd0) r = 5'd9;
      else if (b == 5'd1) r = 5'd10;
      else if (b == 5'd20) r = 5'd11;
    end else if (a == 5'd13) begin
      if (b == 5'd4) r = 5'd14;
      else if (b == 5'd5) r = 5'd15;
      else if (b == 5'd20) r = 5'd16;
    end else if (a == 5'd18 && b == 5'd20) begin
      r = 5'd19;
    end
    return r;
  endfunction

  function automatic logic [4:0] merge_final(input logic [4:0] f, input logic [4:0] c);
    logic [4:0] r;
    r = NONE_IDX;
    if (f == 5'd1 && c == 5'd9) r = 5'd3;
    else if (f == 5'd4 && c == 5'd12) r = 5'd5;
    else if (f == 5'd4 && c == 5'd18) r = 5'd6;
    else if (f == 5'd17 && c == 5'd9) r = 5'd18;
    else if (f == 5'd8) begin
      case (c)
        5'd0:  r = 5'd9;
        5'd6:  r = 5'd10;
        5'd7:  r = 5'd11;
        5'd9:  r = 5'd12;
        5'd16: r = 5'd13;
        5'd17: r = 5'd14;
        5'd18: r = 5'd15;
        default: r = NONE_IDX;
      endcase
    end
    return r;
  endfunction

  function automatic logic [4:0] kept_final(input logic [4:0] f);
    logic [4:0] r;
    case (f)
      5'd3:                                  r = 5'd1;
      5'd5, 5'd6:                            r = 5'd4;
      5'd9, 5'd10, 5'd11, 5'd12, 5'd13,
      5'd14, 5'd15:                          r = 5'd8;
      5'd18:                                 r = 5'd17;
      default:                               r = NONE_IDX;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] moved_initial(input logic [4:0] f);
    logic [4:0] r;
    case (f)
      5'd3:  r = 5'd9;   5'd5:  r = 5'd12;  5'd6:  r = 5'd18;
      5'd9:  r = 5'd0;   5'd10: r = 5'd6;   5'd11: r = 5'd7;
      5'd12: r = 5'd9;   5'd13: r = 5'd16;  5'd14: r = 5'd17;
      5'd15: r = 5'd18;  5'd18: r = 5'd9;
      default: r = NONE_IDX;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] syl_code(input logic [4:0] ini, input logic [4:0] med,
                                           input logic [4:0] fin);
    logic [15:0] f16;
    f16 = (fin <= MAX_FIN) ? {11'd0, fin} : 16'd0;
    return SYL_BASE + {11'd0, ini} * INI_STRIDE + {11'd0, med} * MED_STRIDE + f16;
  endfunction

endpackage

// ----- src/htsc_front.sv -----
// Front end: accepts keystrokes, runs the composition automaton and builds edit jobs.
// Depends on htsc_pkg; feeds htsc_queue.
module htsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              q_full,
  input  htsc_pkg::in_item_t in_item,
  output logic              q_push,
  output htsc_pkg::job_t    q_job
);

  htsc_pkg::phase_t ph_r, ph_nxt;
  logic [4:0] ini_r, ini_nxt;
  logic [4:0] med_r, med_nxt;
  logic [4:0] fin_r, fin_nxt;
  logic       shown_r, shown_nxt;

  logic [4:0] c_idx, u_idx, o_idx;
  logic       c_v, u_v, o_v, accept;

  assign c_idx  = htsc_pkg::key_initial(in_item.key_code);
  assign u_idx  = htsc_pkg::key_medial(in_item.key_code);
  assign o_idx  = htsc_pkg::key_final(in_item.key_code);
  assign c_v    = (c_idx != htsc_pkg::NONE_IDX);
  assign u_v    = (u_idx != htsc_pkg::NONE_IDX);
  assign o_v    = (o_idx != htsc_pkg::NONE_IDX);
  assign accept = push && !q_full;

  always_comb begin
    htsc_pkg::phase_t ph_w;
    logic [4:0] ini_w, med_w, fin_w, mrg, new_ini, split_fin;
    logic       sh_w, restart, split, show;
    htsc_pkg::job_t job;

    ph_w      = ph_r;
    ini_w     = ini_r;
    med_w     = med_r;
    fin_w     = fin_r;
    sh_w      = shown_r;
    restart   = 1'b0;
    split     = 1'b0;
    show      = 1'b0;
    mrg       = htsc_pkg::NONE_IDX;
    new_ini   = htsc_pkg::NONE_IDX;
    split_fin = htsc_pkg::NONE_IDX;
    job       = '0;
    q_push    = 1'b0;

    if (accept) begin
      if (in_item.cmd == htsc_pkg::CMD_COMMIT) begin
        ph_w  = htsc_pkg::PH_IDLE;
        ini_w = htsc_pkg::NONE_IDX;
        med_w = htsc_pkg::NONE_IDX;
        fin_w = htsc_pkg::NONE_IDX;
        sh_w  = 1'b0;
      end else if (!c_v && !u_v) begin
        ph_w          = htsc_pkg::PH_IDLE;
        ini_w         = htsc_pkg::NONE_IDX;
        med_w         = htsc_pkg::NONE_IDX;
        fin_w         = htsc_pkg::NONE_IDX;
        sh_w          = 1'b0;
        job.pass      = 1'b1;
        job.pass_byte = in_item.key_code;
        q_push        = 1'b1;
      end else begin
        case (ph_r)
          htsc_pkg::PH_INI: begin
            if (u_v) begin
              ph_w  = htsc_pkg::PH_MED;
              med_w = u_idx;
            end else begin
              restart = 1'b1;
            end
          end
          htsc_pkg::PH_MED: begin
            mrg = htsc_pkg::merge_vowel(med_r, u_idx);
            if (o_v) begin
              ph_w  = htsc_pkg::PH_FIN;
              fin_w = o_idx;
            end else if (u_v && mrg != htsc_pkg::NONE_IDX) begin
              med_w = mrg;
            end else begin
              restart = 1'b1;
            end
          end
          htsc_pkg::PH_FIN: begin
            mrg = htsc_pkg::merge_final(fin_r, c_idx);
            if (u_v) begin
              split     = 1'b1;
              new_ini   = htsc_pkg::fin_to_ini(fin_r);
              split_fin = htsc_pkg::NONE_IDX;
            end else if (mrg != htsc_pkg::NONE_IDX) begin
              ph_w  = htsc_pkg::PH_CMP;
              fin_w = mrg;
            end else begin
              restart = 1'b1;
            end
          end
          htsc_pkg::PH_CMP: begin
            if (u_v) begin
              split     = 1'b1;
              new_ini   = htsc_pkg::moved_initial(fin_r);
              split_fin = htsc_pkg::kept_final(fin_r);
            end else begin
              restart = 1'b1;
            end
          end
          default: begin
            restart = 1'b1;
          end
        endcase

        if (restart) begin
          ph_w  = c_v ? htsc_pkg::PH_INI : htsc_pkg::PH_IDLE;
          ini_w = c_idx;
          med_w = htsc_pkg::NONE_IDX;
          fin_w = htsc_pkg::NONE_IDX;
          sh_w  = 1'b0;
        end

        if (split) begin
          job.del   = shown_r;
          job.a_ins = (med_r != htsc_pkg::NONE_IDX) && (ini_r <= htsc_pkg::MAX_INI) &&
                      (med_r <= htsc_pkg::MAX_MED);
          job.a_ini = ini_r;
          job.a_med = med_r;
          job.a_fin = split_fin;
          job.b_ins = (new_ini <= htsc_pkg::MAX_INI) && (u_idx <= htsc_pkg::MAX_MED);
          job.b_ini = new_ini;
          job.b_med = u_idx;
          job.b_fin = htsc_pkg::NONE_IDX;
          ph_w      = htsc_pkg::PH_MED;
          ini_w     = new_ini;
          med_w     = u_idx;
          fin_w     = htsc_pkg::NONE_IDX;
          sh_w      = 1'b1;
        end else begin
          show      = (ph_w != htsc_pkg::PH_IDLE) && (med_w != htsc_pkg::NONE_IDX);
          job.del   = sh_w;
          job.a_ins = show && (ini_w <= htsc_pkg::MAX_INI) && (med_w <= htsc_pkg::MAX_MED);
          job.a_ini = ini_w;
          job.a_med = med_w;
          job.a_fin = fin_w;
          sh_w      = show;
        end
        q_push = job.del || job.a_ins || job.b_ins;
      end
    end

    ph_nxt    = ph_w;
    ini_nxt   = ini_w;
    med_nxt   = med_w;
    fin_nxt   = fin_w;
    shown_nxt = sh_w;
    q_job     = job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= htsc_pkg::PH_IDLE;
      ini_r   <= htsc_pkg::NONE_IDX;
      med_r   <= htsc_pkg::NONE_IDX;
      fin_r   <= htsc_pkg::NONE_IDX;
      shown_r <= 1'b0;
    end else begin
      ph_r    <= ph_nxt;
      ini_r   <= ini_nxt;
      med_r   <= med_nxt;
      fin_r   <= fin_nxt;
      shown_r <= shown_nxt;
    end
  end

  a_shown_needs_phase: assert property (@(posedge clk) disable iff (!rst_n)
    shown_r |-> (ph_r != htsc_pkg::PH_IDLE && med_r != htsc_pkg::NONE_IDX))
    else $error("syllable marked shown without a composing vowel");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == htsc_pkg::PH_IDLE) |->
      (ini_r == htsc_pkg::NONE_IDX && med_r == htsc_pkg::NONE_IDX &&
       fin_r == htsc_pkg::NONE_IDX))
    else $error("idle phase holds stale jamo indices");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (accept && in_item.cmd == htsc_pkg::CMD_KEY))
    else $error("job pushed without an accepted keystroke");

endmodule

// ----- src/htsc_queue.sv -----
// Small job queue between the composer front end and the output sequencer.
// Depends on htsc_pkg for the job type.
module htsc_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  htsc_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output htsc_pkg::job_t rd_job,
  output logic           q_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  htsc_pkg::job_t slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("job queue count beyond depth");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full))
    else $error("job written into a full queue");

  a_ptr_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");

endmodule

// ----- src/htsc_back.sv -----
// Back end: walks each job one edit command per cycle, while pop keeps up, into the output register.
// Depends on htsc_pkg; reads jobs from htsc_queue.
module htsc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  htsc_pkg::job_t        q_job,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output htsc_pkg::out_item_t   out_item
);

  htsc_pkg::job_t      job_r, job_nxt;
  logic [9:0]          mask_r, mask_nxt;
  logic                out_valid_r, out_valid_nxt;
  htsc_pkg::out_item_t out_r, out_nxt;

  logic [9:0]  low, mask_left;
  logic [3:0]  idx;
  logic        emit, can_load, grp_b;
  logic [15:0] code;

  assign empty    = !out_valid_r;
  assign out_item = out_r;
  assign can_load = !out_valid_r || pop;
  assign emit     = can_load && (mask_r != '0);
  assign low      = mask_r & (~mask_r + 10'd1);

  always_comb begin
    idx = '0;
    for (int k = 9; k >= 0; k--) begin
      if (mask_r[k]) begin
        idx = 4'(k);
      end
    end
  end

  assign grp_b = (idx >= 4'd6);
  assign code  = grp_b ? htsc_pkg::syl_code(job_r.b_ini, job_r.b_med, job_r.b_fin)
                       : htsc_pkg::syl_code(job_r.a_ini, job_r.a_med, job_r.a_fin);

  always_comb begin
    out_nxt      = out_r;
    out_nxt.last = ((mask_r & ~low) == '0);
    case (idx)
      4'd3, 4'd6: begin
        out_nxt.action     = htsc_pkg::ACT_INSERT;
        out_nxt.byte_value = htsc_pkg::UTF8_LEAD3 | {4'd0, code[15:12]};
      end
      4'd4, 4'd7: begin
        out_nxt.action     = htsc_pkg::ACT_INSERT;
        out_nxt.byte_value = htsc_pkg::UTF8_CONT | {2'd0, code[11:6] & htsc_pkg::UTF8_MASK6};
      end
      4'd5, 4'd8: begin
        out_nxt.action     = htsc_pkg::ACT_INSERT;
        out_nxt.byte_value = htsc_pkg::UTF8_CONT | {2'd0, code[5:0] & htsc_pkg::UTF8_MASK6};
      end
      4'd9: begin
        out_nxt.action     = htsc_pkg::ACT_INSERT;
        out_nxt.byte_value = job_r.pass_byte;
      end
      default: begin
        out_nxt.action     = htsc_pkg::ACT_DELETE;
        out_nxt.byte_value = 8'd0;
      end
    endcase
  end

  always_comb begin
    mask_left     = emit ? (mask_r & ~low) : mask_r;
    q_pop         = !q_empty && (mask_left == '0);
    job_nxt       = q_pop ? q_job : job_r;
    mask_nxt      = q_pop ? {q_job.pass, {3{q_job.b_ins}}, {3{q_job.a_ins}}, {3{q_job.del}}}
                          : mask_left;
    out_valid_nxt = emit ? 1'b1 : (pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= job_nxt;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_pass_alone: assert property (@(posedge clk) disable iff (!rst_n)
    mask_r[9] |-> (mask_r[8:0] == '0))
    else $error("passthrough mixed with syllable edits");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |-> (mask_r != '0))
    else $error("non-final result with nothing left of its job");

  a_emit_on_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pop) |=> ($stable(out_r) && out_valid_r))
    else $error("waiting result overwritten");

endmodule

// ----- src/hangul_two_set_composer_core.sv -----
// Top level of the two-set Hangul composer: front end, job queue and output sequencer.
// Depends on htsc_pkg, htsc_front, htsc_queue and htsc_back.
//
// Keystrokes enter through push/full and are classified combinationally, so a new key
// can be taken every cycle while the job queue (QUEUE_DEPTH entries) has room.
// Each key yields 0 to 9 edit commands (three deletes of the shown syllable and up
// to two syllables of three UTF-8 bytes each, or a single passthrough byte); the
// output sequencer issues one command per cycle while pop keeps up, and the result
// port sets the sustained rate. Commits and keys that change nothing on screen
// produce no result.
module hangul_two_set_composer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  htsc_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output htsc_pkg::out_item_t out_item
);

  logic           q_push, q_pop, q_empty;
  htsc_pkg::job_t q_wr_job, q_rd_job;

  htsc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_full  (full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_job   (q_wr_job)
  );

  htsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_job  (q_wr_job),
    .full    (full),
    .rd_en   (q_pop),
    .rd_job  (q_rd_job),
    .q_empty (q_empty)
  );

  htsc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_job    (q_rd_job),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
